FILE: rtl/core/msr_pkg.sv
// Shared types, constants and the CRC step for the Modbus slave responder.
// Depends on nothing; every other file of the block imports it.
package msr_pkg;

   localparam int COIL_COUNT_DEF       = 256;
   localparam int INPUT_BIT_COUNT_DEF  = 256;
   localparam int HOLDING_COUNT_DEF    = 64;
   localparam int INPUT_WORD_COUNT_DEF = 64;
   localparam int FRAME_BYTES_DEF      = 256;

   localparam int POS_W       = 9;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] BIT_QTY_MAX   = 16'h07D0;
   localparam logic [15:0] REG_QTY_MAX   = 16'h007D;
   localparam logic [15:0] WRITE_QTY_MAX = 16'h007B;
   localparam logic [15:0] COIL_ON       = 16'hFF00;
   localparam logic [15:0] COIL_OFF      = 16'h0000;
   localparam logic [7:0]  EXC_FLAG      = 8'h80;
   localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

   localparam logic [7:0] FC_READ_COILS      = 8'd1;
   localparam logic [7:0] FC_READ_INPUTS     = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
   localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
   localparam logic [7:0] FC_WRITE_REG       = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTI     = 8'd16;

   localparam logic [7:0] EXC_NONE             = 8'd0;
   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
   localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;

   localparam logic [1:0] KIND_REQUEST    = 2'd0;
   localparam logic [1:0] KIND_INPUT_BIT  = 2'd1;
   localparam logic [1:0] KIND_INPUT_WORD = 2'd2;

   localparam logic [1:0] CMD_NONE       = 2'd0;
   localparam logic [1:0] CMD_BYTE       = 2'd1;
   localparam logic [1:0] CMD_INPUT_BIT  = 2'd2;
   localparam logic [1:0] CMD_INPUT_WORD = 2'd3;

   localparam logic REG_SLAVE_ADDRESS   = 1'b0;
   localparam logic REG_FUNCTION_ENABLE = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic        frame_end;
      logic [7:0]  point_index;
      logic [15:0] point_value;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_out_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic [7:0] slave_address;
      logic [6:0] function_enable;
   } cfg_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/msr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on msr_pkg for the address width helper.
module msr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  write_enable,
   input  logic [msr_pkg::addr_bits(DEPTH)-1:0]  write_address,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic [msr_pkg::addr_bits(DEPTH)-1:0]  read_address,
   output logic [WIDTH-1:0]                      read_data
);
   import msr_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/core/msr_front.sv
// Front end: takes input words, sorts them into commands and queues them.
// Depends on msr_pkg for the queue entry and status types.
module msr_front #(
   parameter int INPUT_BIT_COUNT  = msr_pkg::INPUT_BIT_COUNT_DEF,
   parameter int INPUT_WORD_COUNT = msr_pkg::INPUT_WORD_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_frame_end,
   input  logic [7:0]               req_point_index,
   input  logic [15:0]              req_point_value,
   output msr_pkg::queue_out_type   queue_out,
   input  logic                     pop,
   input  msr_pkg::back_status_type back_status
);
   import msr_pkg::*;

   localparam int PTR_W = addr_bits(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   queue_entry_type   entry;
   logic              accept;
   logic              push;
   logic              do_pop;
   logic              full;

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign busy   = full | back_status.clearing;
   assign accept = start & ~busy;
   assign do_pop = pop & (count_ff != '0);

   always_comb begin
      entry.cmd         = CMD_NONE;
      entry.data_byte   = req_data_byte;
      entry.frame_end   = req_frame_end;
      entry.point_index = req_point_index;
      entry.point_value = req_point_value;
      case (req_kind)
         KIND_REQUEST: begin
            entry.cmd = CMD_BYTE;
         end
         KIND_INPUT_BIT: begin
            if (32'(req_point_index) < INPUT_BIT_COUNT) entry.cmd = CMD_INPUT_BIT;
         end
         KIND_INPUT_WORD: begin
            if (32'(req_point_index) < INPUT_WORD_COUNT) entry.cmd = CMD_INPUT_WORD;
         end
         default: begin
            entry.cmd = CMD_NONE;
         end
      endcase
   end

   assign push = accept & (entry.cmd != CMD_NONE);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign queue_out.valid = (count_ff != '0);
   assign queue_out.entry = mem_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/msr_back.sv
// Back end: stores request bytes and points, serves a finished frame and
// streams the reply with its CRC. Depends on msr_pkg and msr_ram.
module msr_back #(
   parameter int COIL_COUNT       = msr_pkg::COIL_COUNT_DEF,
   parameter int INPUT_BIT_COUNT  = msr_pkg::INPUT_BIT_COUNT_DEF,
   parameter int HOLDING_COUNT    = msr_pkg::HOLDING_COUNT_DEF,
   parameter int INPUT_WORD_COUNT = msr_pkg::INPUT_WORD_COUNT_DEF,
   parameter int FRAME_BYTES      = msr_pkg::FRAME_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  msr_pkg::queue_out_type   queue_out,
   output logic                     pop,
   output msr_pkg::back_status_type back_status,
   input  msr_pkg::cfg_type         cfg,
   output logic                     rsp_valid,
   output logic [63:0]              rsp_reply_bytes,
   output logic [3:0]               rsp_reply_count,
   output logic                     rsp_reply_last
);
   import msr_pkg::*;

   localparam int REQ_AW   = addr_bits(FRAME_BYTES);
   localparam int LEN_W    = $clog2(FRAME_BYTES + 1);
   localparam int COIL_AW  = addr_bits(COIL_COUNT);
   localparam int IBIT_AW  = addr_bits(INPUT_BIT_COUNT);
   localparam int HOLD_AW  = addr_bits(HOLDING_COUNT);
   localparam int IWORD_AW = addr_bits(INPUT_WORD_COUNT);
   localparam int MAX_A    = (COIL_COUNT > INPUT_BIT_COUNT) ? COIL_COUNT : INPUT_BIT_COUNT;
   localparam int MAX_B    = (HOLDING_COUNT > INPUT_WORD_COUNT) ? HOLDING_COUNT
                                                                : INPUT_WORD_COUNT;
   localparam int CLR_DEPTH = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int CLR_W     = addr_bits(CLR_DEPTH);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HDR   = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_WR16  = 4'd4;
   localparam logic [3:0] S_HEAD  = 4'd5;
   localparam logic [3:0] S_BITS  = 4'd6;
   localparam logic [3:0] S_WORDS = 4'd7;
   localparam logic [3:0] S_CRC   = 4'd8;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_BITS  = 2'd1;
   localparam logic [1:0] MODE_WORDS = 2'd2;

   logic [3:0]       state_ff, state_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [LEN_W-1:0] req_len_ff, req_len_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [7:0]       hdr_ff [8];
   logic [7:0]       hdr_in [8];
   logic [7:0]       head_ff [8];
   logic [7:0]       head_in [8];
   logic [3:0]       head_len_ff, head_len_in;
   logic [1:0]       mode_ff, mode_in;
   logic             use_crc_ff, use_crc_in;
   logic [7:0]       fc_ff, fc_in;
   logic [15:0]      addr_ff, addr_in;
   logic [15:0]      qty_ff, qty_in;
   logic [10:0]      bitpos_ff, bitpos_in;
   logic [7:0]       acc_ff, acc_in;
   logic [7:0]       hold_ff, hold_in;
   logic [15:0]      crc_ff, crc_in;
   logic [8:0]       out_idx_ff, out_idx_in;
   logic [8:0]       total_ff, total_in;
   logic [63:0]      chunk_ff, chunk_in;
   logic [3:0]       chunk_cnt_ff, chunk_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]       rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                req_we;
   logic [REQ_AW-1:0]   req_waddr, req_raddr;
   logic [7:0]          req_rdata;
   logic                coil_we;
   logic [COIL_AW-1:0]  coil_waddr, coil_raddr;
   logic                coil_wdata, coil_rdata;
   logic                ibit_we;
   logic [IBIT_AW-1:0]  ibit_waddr, ibit_raddr;
   logic                ibit_wdata, ibit_rdata;
   logic                hold_we;
   logic [HOLD_AW-1:0]  hold_waddr, hold_raddr;
   logic [15:0]         hold_wdata, hold_rdata;
   logic                iword_we;
   logic [IWORD_AW-1:0] iword_waddr, iword_raddr;
   logic [15:0]         iword_wdata, iword_rdata;

   logic [7:0]  fc;
   logic [15:0] maddr;
   logic [15:0] mqty;
   logic        known;
   logic        enabled;
   logic [7:0]  exc;
   logic [16:0] span;
   logic [16:0] nb_sum;
   logic [7:0]  nbytes;
   logic [7:0]  req_masked;
   logic [8:0]  wpos;
   logic [16:0] point_addr;
   logic [15:0] word_rdata;
   logic        bit_rdata;
   logic        emit;
   logic        emit_crc;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic [63:0] chunk_next;

   msr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_req_ram (
      .clock(clock), .write_enable(req_we), .write_address(req_waddr),
      .write_data(queue_out.entry.data_byte), .read_address(req_raddr),
      .read_data(req_rdata));

   msr_ram #(.WIDTH(1), .DEPTH(COIL_COUNT)) u_coil_ram (
      .clock(clock), .write_enable(coil_we), .write_address(coil_waddr),
      .write_data(coil_wdata), .read_address(coil_raddr), .read_data(coil_rdata));

   msr_ram #(.WIDTH(1), .DEPTH(INPUT_BIT_COUNT)) u_ibit_ram (
      .clock(clock), .write_enable(ibit_we), .write_address(ibit_waddr),
      .write_data(ibit_wdata), .read_address(ibit_raddr), .read_data(ibit_rdata));

   msr_ram #(.WIDTH(16), .DEPTH(HOLDING_COUNT)) u_hold_ram (
      .clock(clock), .write_enable(hold_we), .write_address(hold_waddr),
      .write_data(hold_wdata), .read_address(hold_raddr), .read_data(hold_rdata));

   msr_ram #(.WIDTH(16), .DEPTH(INPUT_WORD_COUNT)) u_iword_ram (
      .clock(clock), .write_enable(iword_we), .write_address(iword_waddr),
      .write_data(iword_wdata), .read_address(iword_raddr), .read_data(iword_rdata));

   // Frame header decode and the checks, in the order the protocol demands.
   always_comb begin
      fc      = hdr_ff[1];
      maddr   = {hdr_ff[2], hdr_ff[3]};
      mqty    = {hdr_ff[4], hdr_ff[5]};
      span    = {1'b0, maddr} + {1'b0, mqty};
      nb_sum  = {1'b0, mqty} + 17'd7;
      nbytes  = nb_sum[10:3];
      known   = 1'b1;
      enabled = 1'b0;
      exc     = EXC_NONE;
      case (fc)
         FC_READ_COILS:      enabled = cfg.function_enable[0];
         FC_READ_INPUTS:     enabled = cfg.function_enable[1];
         FC_READ_HOLDING:    enabled = cfg.function_enable[2];
         FC_READ_INPUT_REGS: enabled = cfg.function_enable[3];
         FC_WRITE_COIL:      enabled = cfg.function_enable[4];
         FC_WRITE_REG:       enabled = cfg.function_enable[5];
         FC_WRITE_MULTI:     enabled = cfg.function_enable[6];
         default:            known   = 1'b0;
      endcase
      if (!enabled) begin
         exc = EXC_ILLEGAL_FUNCTION;
      end else begin
         case (fc)
            FC_READ_COILS: begin
               if (mqty == 16'd0 || mqty > BIT_QTY_MAX) exc = EXC_ILLEGAL_VALUE;
               else if (32'(span) > COIL_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
            FC_READ_INPUTS: begin
               if (mqty == 16'd0 || mqty > BIT_QTY_MAX) exc = EXC_ILLEGAL_VALUE;
               else if (32'(span) > INPUT_BIT_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
            FC_READ_HOLDING: begin
               if (mqty == 16'd0 || mqty > REG_QTY_MAX) exc = EXC_ILLEGAL_VALUE;
               else if (32'(span) > HOLDING_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
            FC_READ_INPUT_REGS: begin
               if (mqty == 16'd0 || mqty > REG_QTY_MAX) exc = EXC_ILLEGAL_VALUE;
               else if (32'(span) > INPUT_WORD_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
            FC_WRITE_COIL: begin
               if (mqty != COIL_ON && mqty != COIL_OFF) exc = EXC_ILLEGAL_VALUE;
               else if (32'(maddr) >= COIL_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
            FC_WRITE_REG: begin
               if (32'(maddr) >= HOLDING_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
            default: begin
               if (mqty == 16'd0 || mqty > WRITE_QTY_MAX ||
                   {9'd0, hdr_ff[6]} != {mqty, 1'b0}) exc = EXC_ILLEGAL_VALUE;
               else if (32'(span) > HOLDING_COUNT) exc = EXC_ILLEGAL_ADDRESS;
            end
         endcase
      end
   end

   assign req_masked = rd_ok_ff ? req_rdata : 8'd0;
   assign wpos       = 9'd7 + {bitpos_ff[7:0], 1'b0};
   assign point_addr = {1'b0, addr_ff} + 17'(bitpos_ff);
   assign word_rdata = (fc_ff == FC_READ_HOLDING) ? hold_rdata : iword_rdata;
   assign bit_rdata  = (fc_ff == FC_READ_COILS) ? coil_rdata : ibit_rdata;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      req_len_in   = req_len_ff;
      rd_ok_in     = 1'b0;
      hdr_in       = hdr_ff;
      head_in      = head_ff;
      head_len_in  = head_len_ff;
      mode_in      = mode_ff;
      use_crc_in   = use_crc_ff;
      fc_in        = fc_ff;
      addr_in      = addr_ff;
      qty_in       = qty_ff;
      bitpos_in    = bitpos_ff;
      acc_in       = acc_ff;
      hold_in      = hold_ff;
      crc_in       = crc_ff;
      out_idx_in   = out_idx_ff;
      total_in     = total_ff;
      chunk_in     = chunk_ff;
      chunk_cnt_in = chunk_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      req_we       = 1'b0;
      req_waddr    = req_len_ff[REQ_AW-1:0];
      req_raddr    = '0;
      coil_we      = 1'b0;
      coil_waddr   = COIL_AW'(clr_ff);
      coil_wdata   = 1'b0;
      coil_raddr   = COIL_AW'(point_addr);
      ibit_we      = 1'b0;
      ibit_waddr   = IBIT_AW'(clr_ff);
      ibit_wdata   = 1'b0;
      ibit_raddr   = IBIT_AW'(point_addr);
      hold_we      = 1'b0;
      hold_waddr   = HOLD_AW'(clr_ff);
      hold_wdata   = 16'd0;
      hold_raddr   = HOLD_AW'(point_addr);
      iword_we     = 1'b0;
      iword_waddr  = IWORD_AW'(clr_ff);
      iword_wdata  = 16'd0;
      iword_raddr  = IWORD_AW'(point_addr);
      emit         = 1'b0;
      emit_crc     = 1'b0;
      emit_byte    = 8'd0;
      emit_last    = 1'b0;
      chunk_next   = chunk_ff;

      case (state_ff)
         S_CLEAR: begin
            coil_we  = (32'(clr_ff) < COIL_COUNT);
            ibit_we  = (32'(clr_ff) < INPUT_BIT_COUNT);
            hold_we  = (32'(clr_ff) < HOLDING_COUNT);
            iword_we = (32'(clr_ff) < INPUT_WORD_COUNT);
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (queue_out.valid) begin
               pop = 1'b1;
               case (queue_out.entry.cmd)
                  CMD_BYTE: begin
                     if (32'(req_len_ff) < FRAME_BYTES) begin
                        req_we     = 1'b1;
                        req_len_in = req_len_ff + 1'b1;
                     end
                     if (queue_out.entry.frame_end) begin
                        state_in = S_HDR;
                        cnt_in   = 4'd0;
                     end
                  end
                  CMD_INPUT_BIT: begin
                     ibit_we    = 1'b1;
                     ibit_waddr = IBIT_AW'(queue_out.entry.point_index);
                     ibit_wdata = queue_out.entry.point_value[0];
                  end
                  CMD_INPUT_WORD: begin
                     iword_we    = 1'b1;
                     iword_waddr = IWORD_AW'(queue_out.entry.point_index);
                     iword_wdata = queue_out.entry.point_value;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         S_HDR: begin
            req_raddr = REQ_AW'(cnt_ff);
            rd_ok_in  = (9'(cnt_ff) < 9'(req_len_ff)) && (cnt_ff != 4'd8);
            if (cnt_ff != 4'd0) begin
               hdr_in[3'(cnt_ff - 4'd1)] = req_masked;
            end
            if (cnt_ff == 4'd8) begin
               state_in = S_CHECK;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_CHECK: begin
            fc_in        = fc;
            addr_in      = maddr;
            qty_in       = mqty;
            cnt_in       = 4'd0;
            bitpos_in    = 11'd0;
            crc_in       = CRC_INIT;
            out_idx_in   = 9'd0;
            chunk_in     = 64'd0;
            chunk_cnt_in = 4'd0;
            mode_in      = MODE_PLAIN;
            use_crc_in   = 1'b1;
            head_len_in  = 4'd3;
            head_in[0]   = cfg.slave_address;
            head_in[1]   = fc;
            head_in[2]   = exc;
            total_in     = 9'd5;
            state_in     = S_HEAD;
            if (!known) begin
               req_len_in = '0;
               state_in   = S_IDLE;
            end else if (exc != EXC_NONE) begin
               head_in[1] = fc + EXC_FLAG;
            end else begin
               case (fc)
                  FC_READ_COILS, FC_READ_INPUTS: begin
                     mode_in    = MODE_BITS;
                     head_in[2] = nbytes;
                     total_in   = 9'd5 + 9'(nbytes);
                  end
                  FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
                     mode_in    = MODE_WORDS;
                     head_in[2] = 8'(mqty << 1);
                     total_in   = 9'd5 + 9'(mqty << 1);
                  end
                  FC_WRITE_COIL, FC_WRITE_REG: begin
                     head_in     = hdr_ff;
                     head_len_in = 4'd8;
                     use_crc_in  = 1'b0;
                     total_in    = 9'd8;
                     if (fc == FC_WRITE_COIL) begin
                        coil_we    = 1'b1;
                        coil_waddr = COIL_AW'(maddr);
                        coil_wdata = (mqty == COIL_ON);
                     end else begin
                        hold_we    = 1'b1;
                        hold_waddr = HOLD_AW'(maddr);
                        hold_wdata = mqty;
                     end
                  end
                  default: begin
                     head_in     = hdr_ff;
                     head_len_in = 4'd6;
                     total_in    = 9'd8;
                     state_in    = S_WR16;
                  end
               endcase
            end
         end
         S_WR16: begin
            case (cnt_ff)
               4'd0: begin
                  req_raddr = REQ_AW'(wpos);
                  rd_ok_in  = (wpos < 9'(req_len_ff));
                  cnt_in    = 4'd1;
               end
               4'd1: begin
                  hold_in   = req_masked;
                  req_raddr = REQ_AW'(wpos + 9'd1);
                  rd_ok_in  = ((wpos + 9'd1) < 9'(req_len_ff));
                  cnt_in    = 4'd2;
               end
               default: begin
                  hold_we    = 1'b1;
                  hold_waddr = HOLD_AW'(point_addr);
                  hold_wdata = {hold_ff, req_masked};
                  cnt_in     = 4'd0;
                  if (16'(bitpos_ff) + 16'd1 == qty_ff) begin
                     bitpos_in = 11'd0;
                     state_in  = S_HEAD;
                  end else begin
                     bitpos_in = bitpos_ff + 11'd1;
                  end
               end
            endcase
         end
         S_HEAD: begin
            emit      = 1'b1;
            emit_byte = head_ff[cnt_ff[2:0]];
            if (cnt_ff == head_len_ff - 4'd1) begin
               cnt_in    = 4'd0;
               bitpos_in = 11'd0;
               case (mode_ff)
                  MODE_BITS:  state_in = S_BITS;
                  MODE_WORDS: state_in = S_WORDS;
                  default: begin
                     if (use_crc_ff) begin
                        state_in = S_CRC;
                     end else begin
                        req_len_in = '0;
                        state_in   = S_IDLE;
                     end
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_BITS: begin
            if (cnt_ff < 4'd8) begin
               rd_ok_in  = (16'(bitpos_ff) < qty_ff);
               bitpos_in = bitpos_ff + 11'd1;
            end
            if (cnt_ff != 4'd0 && cnt_ff != 4'd9) begin
               acc_in[3'(cnt_ff - 4'd1)] = rd_ok_ff & bit_rdata;
            end
            if (cnt_ff == 4'd9) begin
               emit      = 1'b1;
               emit_byte = acc_ff;
               cnt_in    = 4'd0;
               if (16'(bitpos_ff) >= qty_ff) state_in = S_CRC;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_WORDS: begin
            case (cnt_ff)
               4'd0: begin
                  cnt_in = 4'd1;
               end
               4'd1: begin
                  emit      = 1'b1;
                  emit_byte = word_rdata[15:8];
                  hold_in   = 8'(word_rdata & LOW_BYTE_MASK);
                  cnt_in    = 4'd2;
               end
               default: begin
                  emit      = 1'b1;
                  emit_byte = hold_ff;
                  cnt_in    = 4'd0;
                  if (16'(bitpos_ff) + 16'd1 == qty_ff) begin
                     state_in = S_CRC;
                  end else begin
                     bitpos_in = bitpos_ff + 11'd1;
                  end
               end
            endcase
         end
         S_CRC: begin
            emit     = 1'b1;
            emit_crc = 1'b1;
            if (cnt_ff == 4'd0) begin
               emit_byte = crc_ff[7:0];
               cnt_in    = 4'd1;
            end else begin
               emit_byte  = crc_ff[15:8];
               req_len_in = '0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         chunk_next = chunk_ff | (64'(emit_byte) << {chunk_cnt_ff[2:0], 3'b000});
         emit_last  = (out_idx_ff == total_ff - 9'd1);
         out_idx_in = out_idx_ff + 9'd1;
         if (!emit_crc) crc_in = crc16_byte(crc_ff, emit_byte);
         if (chunk_cnt_ff == 4'd7 || emit_last) begin
            rsp_valid_in = 1'b1;
            rsp_bytes_in = chunk_next;
            rsp_count_in = chunk_cnt_ff + 4'd1;
            rsp_last_in  = emit_last;
            chunk_in     = 64'd0;
            chunk_cnt_in = 4'd0;
         end else begin
            chunk_in     = chunk_next;
            chunk_cnt_in = chunk_cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= 4'd0;
         clr_ff       <= '0;
         req_len_ff   <= '0;
         rd_ok_ff     <= 1'b0;
         chunk_cnt_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         req_len_ff   <= req_len_in;
         rd_ok_ff     <= rd_ok_in;
         chunk_cnt_ff <= chunk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      head_ff      <= head_in;
      head_len_ff  <= head_len_in;
      mode_ff      <= mode_in;
      use_crc_ff   <= use_crc_in;
      fc_ff        <= fc_in;
      addr_ff      <= addr_in;
      qty_ff       <= qty_in;
      bitpos_ff    <= bitpos_in;
      acc_ff       <= acc_in;
      hold_ff      <= hold_in;
      crc_ff       <= crc_in;
      out_idx_ff   <= out_idx_in;
      total_ff     <= total_in;
      chunk_ff     <= chunk_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign back_status.clearing = (state_ff == S_CLEAR);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_reply_bytes      = rsp_bytes_ff;
   assign rsp_reply_count      = rsp_count_ff;
   assign rsp_reply_last       = rsp_last_ff;

endmodule

FILE: rtl/core/modbus_slave_responder.sv
// Top level of the Modbus RTU slave responder: configuration registers,
// front queue and back end. Depends on msr_pkg, msr_front and msr_back.
//
// After reset the block clears its point stores, one entry a cycle, across as
// many entries as the largest of COIL_COUNT, INPUT_BIT_COUNT, HOLDING_COUNT and
// INPUT_WORD_COUNT; busy stays high meanwhile. The back end takes request
// bytes and point updates from a two-word queue in front of it while idle.
// The byte that ends a frame starts the header fetch and checks, then, for
// a multiple-register write, the register writes, then the reply: the fixed
// bytes, two bytes per register read, coil or input bits read one bit a
// cycle and packed into bytes, and the CRC. Each reply chunk of up to eight
// bytes is shown for one cycle on rsp_valid and cannot be held off.
module modbus_slave_responder #(
   parameter int COIL_COUNT       = msr_pkg::COIL_COUNT_DEF,
   parameter int INPUT_BIT_COUNT  = msr_pkg::INPUT_BIT_COUNT_DEF,
   parameter int HOLDING_COUNT    = msr_pkg::HOLDING_COUNT_DEF,
   parameter int INPUT_WORD_COUNT = msr_pkg::INPUT_WORD_COUNT_DEF,
   parameter int FRAME_BYTES      = msr_pkg::FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   input  logic [7:0]  req_point_index,
   input  logic [15:0] req_point_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_reply_bytes,
   output logic [3:0]  rsp_reply_count,
   output logic        rsp_reply_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);
   import msr_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   queue_out_type   queue_out;
   back_status_type back_status;
   logic            pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_SLAVE_ADDRESS:   cfg_in.slave_address   = csr_write_data;
            REG_FUNCTION_ENABLE: cfg_in.function_enable = csr_write_data[6:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address   <= 8'd1;
         cfg_ff.function_enable <= 7'h7F;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msr_front #(
      .INPUT_BIT_COUNT(INPUT_BIT_COUNT),
      .INPUT_WORD_COUNT(INPUT_WORD_COUNT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_data_byte(req_data_byte),
      .req_frame_end(req_frame_end),
      .req_point_index(req_point_index),
      .req_point_value(req_point_value),
      .queue_out(queue_out),
      .pop(pop),
      .back_status(back_status)
   );

   msr_back #(
      .COIL_COUNT(COIL_COUNT),
      .INPUT_BIT_COUNT(INPUT_BIT_COUNT),
      .HOLDING_COUNT(HOLDING_COUNT),
      .INPUT_WORD_COUNT(INPUT_WORD_COUNT),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_out(queue_out),
      .pop(pop),
      .back_status(back_status),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_reply_bytes(rsp_reply_bytes),
      .rsp_reply_count(rsp_reply_count),
      .rsp_reply_last(rsp_reply_last)
   );

   // A word always carries between one and eight bytes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reply_count != 4'd0 && rsp_reply_count <= 4'd8))
      else $error("reply word with an invalid byte count");

   // Only the final word of a reply may be short.
   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reply_last) |-> (rsp_reply_count == 4'd8))
      else $error("short reply word before the end of a reply");

   // No reply is produced while the stores are being cleared.
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> (!rsp_valid && busy))
      else $error("activity during the clearing pass");

endmodule
